// File: hdl/mae_pkg.sv
`timescale 1ns / 1ps

package mae_pkg;

    localparam int VAL_W     = 36;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int IN_DAT_W  = 24;
    localparam int OUT_DAT_W = 48;
    localparam int QDEPTH    = 4;
    localparam int QPW       = 2;

    localparam logic [VAL_W-1:0] VAL_MAX = 36'h7_FFFF_FFFF;

    // input item kinds
    localparam logic [1:0] KIND_WR_A = 2'd0;
    localparam logic [1:0] KIND_WR_B = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // operating modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_SUB   = 2'd1;
    localparam logic [1:0] MODE_MUL   = 2'd2;
    localparam logic [1:0] MODE_SCALE = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd5;

    typedef enum logic [1:0] {
        CMD_WR_A = 2'd0,
        CMD_WR_B = 2'd1,
        CMD_RUN  = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [15:0] elem;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         op_mode;
        logic [3:0]         a_rows;
        logic [3:0]         a_cols;
        logic [3:0]         b_rows;
        logic [3:0]         b_cols;
        logic signed [15:0] scale;
    } cfg_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic       k_first;
        logic       k_last;
        logic       e_last;
        logic       err;
    } tag_t;

endpackage

// File: hdl/mae_front.sv
`timescale 1ns / 1ps

module mae_front #(
    parameter int MAX_DIM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mae_pkg::IN_DAT_W-1:0]  s_tdata,   // row_index, col_index, element
    input  logic [1:0]                    s_tuser,   // kind
    output mae_pkg::cmd_t                 cmd,
    output logic                          cmd_valid,
    input  logic                          cmd_ready
);
    import mae_pkg::*;

    logic       hold_v_reg;
    logic       hold_v_next;
    cmd_t       hold_reg;
    cmd_t       dec;
    logic       keep;
    logic       accept;
    logic [2:0] row_in;
    logic [2:0] col_in;
    logic       in_range;

    assign row_in   = s_tdata[2:0];
    assign col_in   = s_tdata[5:3];
    assign in_range = ({1'b0, row_in} < 4'(MAX_DIM)) && ({1'b0, col_in} < 4'(MAX_DIM));

    always_comb
    begin
        dec.row  = row_in;
        dec.col  = col_in;
        dec.elem = $signed(s_tdata[21:6]);
        dec.op   = CMD_RUN;
        keep     = 1'b0;
        unique case (s_tuser) inside
            KIND_WR_A, KIND_WR_B:
            begin
                dec.op = (s_tuser == KIND_WR_A) ? CMD_WR_A : CMD_WR_B;
                keep   = in_range;
            end
            KIND_RUN:
            begin
                dec.op = CMD_RUN;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !hold_v_reg || cmd_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hold_v_next = hold_v_reg;
        if (accept)
        begin
            hold_v_next = keep;
        end
        else if (cmd_ready)
        begin
            hold_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
        end
        else
        begin
            hold_v_reg <= hold_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= dec;
        end
    end

    assign cmd       = hold_reg;
    assign cmd_valid = hold_v_reg;

endmodule

// File: hdl/mae_queue.sv
`timescale 1ns / 1ps

module mae_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  mae_pkg::cmd_t push_cmd,
    input  logic          push_valid,
    output logic          push_ready,
    output mae_pkg::cmd_t pop_cmd,
    output logic          pop_valid,
    input  logic          pop_ready
);
    import mae_pkg::*;

    cmd_t           q_mem_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QPW:0]   count_reg;
    logic [QPW:0]   count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != (QPW+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/mae_back.sv
`timescale 1ns / 1ps

module mae_back #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mae_pkg::cfg_t                  cfg,
    input  mae_pkg::cmd_t                  cmd,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mae_pkg::OUT_DAT_W-1:0]  m_tdata,   // value, out_row, out_col
    output logic                           m_tlast,
    output logic                           m_tuser    // error
);
    import mae_pkg::*;

    localparam int IW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADW   = $clog2(DEPTH);
    localparam int EW    = ELEM_WIDTH;
    localparam int OW    = (EW > 16) ? EW : 16;
    localparam int PW    = EW + OW;
    localparam int AW    = PW + IW;
    localparam int SW    = (AW > VAL_W) ? AW : VAL_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    function automatic logic [3:0] eff_dim(input logic [3:0] v);
        logic [3:0] r;
        r = v;
        if (v == 4'd0)
        begin
            r = 4'd1;
        end
        else if (v > 4'(MAX_DIM))
        begin
            r = 4'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [ADW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return ADW'(r) * ADW'(MAX_DIM) + ADW'(c);
    endfunction

    state_t                state_reg;
    state_t                state_next;
    logic [1:0]            mode_reg;
    logic                  err_reg;
    logic [IW-1:0]         lim_r_reg;
    logic [IW-1:0]         lim_c_reg;
    logic [IW-1:0]         lim_k_reg;
    logic [IW-1:0]         i_reg;
    logic [IW-1:0]         j_reg;
    logic [IW-1:0]         k_reg;
    logic [IW-1:0]         i_next;
    logic [IW-1:0]         j_next;
    logic [IW-1:0]         k_next;

    logic signed [EW-1:0]  mem_a [DEPTH];
    logic signed [EW-1:0]  mem_b [DEPTH];
    logic signed [EW-1:0]  a_q_reg;
    logic signed [EW-1:0]  b_q_reg;

    logic                  s1_v_reg;
    tag_t                  s1_tag_reg;
    logic                  s2_v_reg;
    tag_t                  s2_tag_reg;
    logic signed [PW-1:0]  s2_val_reg;
    logic                  s3_v_reg;
    tag_t                  s3_tag_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [AW-1:0]  acc_next;

    logic                  m_valid_reg;
    logic [VAL_W-1:0]      m_value_reg;
    logic [2:0]            m_row_reg;
    logic [2:0]            m_col_reg;
    logic                  m_last_reg;
    logic                  m_err_reg;

    logic                  adv;
    logic                  issue;
    logic                  start;
    logic                  wr_en;
    logic [ADW-1:0]        wr_addr;
    logic signed [EW-1:0]  wr_data;
    logic [ADW-1:0]        rd_addr_a;
    logic [ADW-1:0]        rd_addr_b;
    logic                  k_last;
    logic                  j_last;
    logic                  i_last;
    logic                  e_last;
    tag_t                  s0_tag;

    logic [3:0]            ar;
    logic [3:0]            ac;
    logic [3:0]            br;
    logic [3:0]            bc;
    logic                  mismatch;

    logic signed [OW-1:0]  op2;
    logic signed [PW-1:0]  a_x;
    logic signed [PW-1:0]  b_x;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  s2_val_next;

    logic signed [SW-1:0]  acc_x;
    logic signed [SW-1:0]  max_c;
    logic signed [SW-1:0]  min_c;
    logic signed [SW-1:0]  sat;

    assign adv       = !m_valid_reg || m_tready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign issue     = (state_reg == ST_RUN) && adv;
    assign start     = cmd_valid && cmd_ready && (cmd.op == CMD_RUN);
    assign wr_en     = cmd_valid && cmd_ready && (cmd.op != CMD_RUN);
    assign wr_addr   = addr_of(cmd.row[IW-1:0], cmd.col[IW-1:0]);
    assign wr_data   = EW'($signed(cmd.elem));

    // dimension check on the configured sizes
    assign ar = eff_dim(cfg.a_rows);
    assign ac = eff_dim(cfg.a_cols);
    assign br = eff_dim(cfg.b_rows);
    assign bc = eff_dim(cfg.b_cols);

    always_comb
    begin
        case (cfg.op_mode) inside
            MODE_MUL:              mismatch = (ac != br);
            MODE_ADD, MODE_SUB:    mismatch = (ar != br) || (ac != bc);
            default:               mismatch = 1'b0;
        endcase
    end

    // walk over i, j and the inner index k
    assign k_last = (k_reg == lim_k_reg);
    assign j_last = (j_reg == lim_c_reg);
    assign i_last = (i_reg == lim_r_reg);
    assign e_last = i_last && j_last && k_last;

    always_comb
    begin
        if (mode_reg == MODE_MUL)
        begin
            rd_addr_a = addr_of(i_reg, k_reg);
            rd_addr_b = addr_of(k_reg, j_reg);
        end
        else
        begin
            rd_addr_a = addr_of(i_reg, j_reg);
            rd_addr_b = addr_of(i_reg, j_reg);
        end
    end

    always_comb
    begin
        s0_tag.row     = 3'(i_reg);
        s0_tag.col     = 3'(j_reg);
        s0_tag.k_first = (k_reg == '0);
        s0_tag.k_last  = k_last;
        s0_tag.e_last  = e_last;
        s0_tag.err     = err_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (!k_last)
                    begin
                        k_next = k_reg + 1'b1;
                    end
                    else
                    begin
                        k_next = '0;
                        if (!j_last)
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                    end
                    if (e_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                s1_v_reg    <= issue;
                s2_v_reg    <= s1_v_reg;
                s3_v_reg    <= s2_v_reg && s2_tag_reg.k_last;
                m_valid_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        if (start)
        begin
            mode_reg  <= cfg.op_mode;
            err_reg   <= mismatch;
            lim_r_reg <= mismatch ? '0 : IW'(ar - 4'd1);
            lim_c_reg <= mismatch ? '0 :
                         IW'(((cfg.op_mode == MODE_MUL) ? bc : ac) - 4'd1);
            lim_k_reg <= (mismatch || (cfg.op_mode != MODE_MUL)) ? '0 : IW'(ac - 4'd1);
        end
    end

    // element stores
    always_ff @(posedge clk)
    begin
        if (wr_en && (cmd.op == CMD_WR_A))
        begin
            mem_a[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            a_q_reg <= mem_a[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (cmd.op == CMD_WR_B))
        begin
            mem_b[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            b_q_reg <= mem_b[rd_addr_b];
        end
    end

    // shared multiplier, adder for add and subtract
    assign op2  = (mode_reg == MODE_SCALE) ? OW'($signed(cfg.scale)) : OW'(b_q_reg);
    assign a_x  = PW'(a_q_reg);
    assign b_x  = PW'(b_q_reg);
    assign prod = a_x * PW'(op2);

    always_comb
    begin
        case (mode_reg)
            MODE_ADD: s2_val_next = a_x + b_x;
            MODE_SUB: s2_val_next = a_x - b_x;
            default:  s2_val_next = prod;
        endcase
    end

    assign acc_next = s2_tag_reg.k_first ? AW'(s2_val_reg) : acc_reg + AW'(s2_val_reg);

    // saturation to the result range
    assign acc_x = SW'(acc_reg);
    assign max_c = SW'(VAL_MAX);
    assign min_c = ~max_c;
    assign sat   = (acc_x > max_c) ? max_c : ((acc_x < min_c) ? min_c : acc_x);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= s0_tag;
            s2_tag_reg <= s1_tag_reg;
            s2_val_reg <= s2_val_next;
            if (s2_v_reg)
            begin
                acc_reg    <= acc_next;
                s3_tag_reg <= s2_tag_reg;
            end
            if (s3_v_reg)
            begin
                m_value_reg <= s3_tag_reg.err ? '0 : sat[VAL_W-1:0];
                m_row_reg   <= s3_tag_reg.err ? 3'd0 : s3_tag_reg.row;
                m_col_reg   <= s3_tag_reg.err ? 3'd0 : s3_tag_reg.col;
                m_last_reg  <= s3_tag_reg.e_last;
                m_err_reg   <= s3_tag_reg.err;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_col_reg, m_row_reg, m_value_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

`ifndef ASSERT_OFF
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_value_reg == '0))
        else $error("error beat must be last and zero");

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (i_reg <= lim_r_reg) && (j_reg <= lim_c_reg)
                                  && (k_reg <= lim_k_reg))
        else $error("walk counter beyond limit");

    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        issue && e_last |=> (state_reg == ST_IDLE))
        else $error("walk did not end after last element");
`endif

endmodule

// File: hdl/matrix_arithmetic_engine_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake                   payload
// s_*       in   s_tvalid / s_tready         s_tdata, s_tuser
// m_*       out  m_tvalid / m_tready         m_tdata, m_tlast, m_tuser
// cfg_*     in   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// element writes are taken one per cycle, while the command queue has room, into a 4-entry command queue
// a compute item holds the back end from its start until its walk ends, one step per element read:
// rows*cols (add, subtract, scale), rows*cols*inner (multiply), one for an error run
// a result passes the read registers, s2, the accumulator and the output register (inner 1 unless multiply)
// rst_n clears control state only; store contents are undefined until written
// a stalled m_tready freezes the back-end pipeline while the front keeps filling the queue

module matrix_arithmetic_engine_top #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mae_pkg::IN_DAT_W-1:0]   s_tdata,   // row_index, col_index, element
    input  logic [1:0]                     s_tuser,   // kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mae_pkg::OUT_DAT_W-1:0]  m_tdata,   // value, out_row, out_col
    output logic                           m_tlast,
    output logic                           m_tuser,   // error
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mae_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import mae_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode <= MODE_MUL;
            cfg_reg.a_rows  <= 4'd8;
            cfg_reg.a_cols  <= 4'd8;
            cfg_reg.b_rows  <= 4'd8;
            cfg_reg.b_cols  <= 4'd8;
            cfg_reg.scale   <= 16'sd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OP_MODE: cfg_reg.op_mode <= cfg_data[1:0];
                REG_A_ROWS:  cfg_reg.a_rows  <= cfg_data[3:0];
                REG_A_COLS:  cfg_reg.a_cols  <= cfg_data[3:0];
                REG_B_ROWS:  cfg_reg.b_rows  <= cfg_data[3:0];
                REG_B_COLS:  cfg_reg.b_cols  <= cfg_data[3:0];
                REG_SCALE:   cfg_reg.scale   <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    mae_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    mae_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (q_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    mae_back #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (q_cmd),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// File: tb/mae_result_checker.sv
`timescale 1ns / 1ps

module mae_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mae_pkg::IN_DAT_W-1:0]   s_tdata,   // row_index, col_index, element
    input  logic [1:0]                     s_tuser,   // kind
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mae_pkg::OUT_DAT_W-1:0]  m_tdata,   // value, out_row, out_col
    input  logic                           m_tlast,
    input  logic                           m_tuser,   // error
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mae_pkg::CFG_DAT_W-1:0]  cfg_data,
    output int                             mismatches,
    output int                             outstanding
);
    import mae_pkg::*;

    localparam int STORE_DIM  = 8;
    localparam longint SAT_HI = 64'sd34359738367;
    localparam longint SAT_LO = -64'sd34359738368;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [2:0]       row;
        logic [2:0]       col;
        logic             last;
        logic             err;
    } mat_result_t;

    mat_result_t expected_beats[$];

    logic signed [15:0] a_store [STORE_DIM*STORE_DIM];
    logic signed [15:0] b_store [STORE_DIM*STORE_DIM];

    logic [1:0]         mode_q;
    logic [3:0]         a_rows_q;
    logic [3:0]         a_cols_q;
    logic [3:0]         b_rows_q;
    logic [3:0]         b_cols_q;
    logic signed [15:0] scale_q;

    function automatic int used_dim(logic [3:0] d);
        if (d == 0)
            return 1;
        if (d > STORE_DIM)
            return STORE_DIM;
        return int'(d);
    endfunction

    function automatic longint clamp36(longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    task automatic note_mismatch(string field, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, want %0d", $time, field, got, want);
        mismatches++;
    endtask

    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_OP_MODE: mode_q   = data[1:0];
            REG_A_ROWS:  a_rows_q = data[3:0];
            REG_A_COLS:  a_cols_q = data[3:0];
            REG_B_ROWS:  b_rows_q = data[3:0];
            REG_B_COLS:  b_cols_q = data[3:0];
            REG_SCALE:   scale_q  = data;
            default:     ;
        endcase
    endtask

    task automatic predict_run();
        int ar;
        int ac;
        int br;
        int bc;
        int nr;
        int nc;
        int i;
        int j;
        int k;
        longint v;
        mat_result_t beat;
        ar = used_dim(a_rows_q);
        ac = used_dim(a_cols_q);
        br = used_dim(b_rows_q);
        bc = used_dim(b_cols_q);
        if ((mode_q == MODE_MUL && ac != br) ||
            ((mode_q == MODE_ADD || mode_q == MODE_SUB) && (ar != br || ac != bc)))
        begin
            beat.value = '0;
            beat.row   = '0;
            beat.col   = '0;
            beat.last  = 1'b1;
            beat.err   = 1'b1;
            expected_beats.push_back(beat);
            return;
        end
        nr = ar;
        nc = (mode_q == MODE_MUL) ? bc : ac;
        for (i = 0; i < nr; i++)
        begin
            for (j = 0; j < nc; j++)
            begin
                case (mode_q)
                    MODE_ADD:
                        v = longint'(a_store[i*STORE_DIM+j]) + longint'(b_store[i*STORE_DIM+j]);
                    MODE_SUB:
                        v = longint'(a_store[i*STORE_DIM+j]) - longint'(b_store[i*STORE_DIM+j]);
                    MODE_MUL:
                    begin
                        v = 0;
                        for (k = 0; k < ac; k++)
                            v += longint'(a_store[i*STORE_DIM+k]) *
                                 longint'(b_store[k*STORE_DIM+j]);
                    end
                    default:
                        v = longint'(a_store[i*STORE_DIM+j]) * longint'(scale_q);
                endcase
                v = clamp36(v);
                beat.value = v[VAL_W-1:0];
                beat.row   = i[2:0];
                beat.col   = j[2:0];
                beat.last  = (i == nr - 1 && j == nc - 1);
                beat.err   = 1'b0;
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic take_command();
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] elem;
        row  = s_tdata[2:0];
        col  = s_tdata[5:3];
        elem = s_tdata[21:6];
        case (s_tuser)
            KIND_WR_A: a_store[{row, col}] = elem;
            KIND_WR_B: b_store[{row, col}] = elem;
            KIND_RUN:  predict_run();
            default:   ;
        endcase
    endtask

    task automatic check_beat();
        mat_result_t want;
        if (expected_beats.size() == 0)
        begin
            note_mismatch("beat with nothing expected",
                          longint'($signed(m_tdata[VAL_W-1:0])), 0);
            return;
        end
        want = expected_beats.pop_front();
        if (m_tdata[VAL_W-1:0] !== want.value)
            note_mismatch("value", longint'($signed(m_tdata[VAL_W-1:0])),
                          longint'($signed(want.value)));
        if (m_tdata[VAL_W+2:VAL_W] !== want.row)
            note_mismatch("out_row", longint'(m_tdata[VAL_W+2:VAL_W]), longint'(want.row));
        if (m_tdata[VAL_W+5:VAL_W+3] !== want.col)
            note_mismatch("out_col", longint'(m_tdata[VAL_W+5:VAL_W+3]), longint'(want.col));
        if (m_tlast !== want.last)
            note_mismatch("last", longint'(m_tlast), longint'(want.last));
        if (m_tuser !== want.err)
            note_mismatch("error", longint'(m_tuser), longint'(want.err));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q   = MODE_MUL;
            a_rows_q = 4'd8;
            a_cols_q = 4'd8;
            b_rows_q = 4'd8;
            b_cols_q = 4'd8;
            scale_q  = 16'sd1;
            foreach (a_store[n])
            begin
                a_store[n] = '0;
                b_store[n] = '0;
            end
            expected_beats.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                take_command();
            if (m_tvalid && m_tready)
                check_beat();
        end
        outstanding = expected_beats.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mae_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int ITEM_TARGET   = 300;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int STORE_DIM     = 8;
    localparam logic [1:0] KIND_NONE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DAT_W-1:0]  s_tdata   = '0;   // row_index, col_index, element
    logic [1:0]           s_tuser   = '0;   // kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_DAT_W-1:0] m_tdata;          // value, out_row, out_col
    logic                 m_tlast;
    logic                 m_tuser;          // error
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int send_idle  = 18;
    int recv_idle  = 85;
    int items_sent = 0;
    int cycles     = 0;

    bit [63:0]   written_a = '0;
    bit [63:0]   written_b = '0;
    logic [1:0]  cur_mode  = MODE_MUL;
    logic [3:0]  cur_ar    = 4'd8;
    logic [3:0]  cur_ac    = 4'd8;
    logic [3:0]  cur_br    = 4'd8;
    logic [3:0]  cur_bc    = 4'd8;

    matrix_arithmetic_engine_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mae_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[matrix_arithmetic_engine_top] ERROR");
            $finish;
        end
    end

    function automatic int dim_of(logic [3:0] d);
        if (d == 0)
            return 1;
        if (d > STORE_DIM)
            return STORE_DIM;
        return int'(d);
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 4'd0;
        if (r < 11)
            return 4'($urandom_range(15, 9));
        if (r < 25)
            return 4'($urandom_range(8, 4));
        return 4'($urandom_range(3, 1));
    endfunction

    task automatic set_pace();
        if (items_sent < ITEM_TARGET / 3)
        begin
            send_idle = 18;
            recv_idle = 85;
        end
        else if (items_sent < 2 * ITEM_TARGET / 3)
        begin
            send_idle = 85;
            recv_idle = 18;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send_beat(logic [1:0] kind, logic [2:0] row, logic [2:0] col,
                             logic [15:0] elem);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, elem, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (kind == KIND_WR_A)
            written_a[{row, col}] = 1'b1;
        if (kind == KIND_WR_B)
            written_b[{row, col}] = 1'b1;
        if (kind != KIND_NONE)
            items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(logic [1:0] mode, logic [3:0] ar, logic [3:0] ac,
                              logic [3:0] br, logic [3:0] bc, logic [15:0] scale);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write(REG_OP_MODE, 16'(mode));
        cfg_write(REG_A_ROWS, 16'(ar));
        cfg_write(REG_A_COLS, 16'(ac));
        cfg_write(REG_B_ROWS, 16'(br));
        cfg_write(REG_B_COLS, 16'(bc));
        cfg_write(REG_SCALE, scale);
        cfg_valid <= 1'b0;
        cur_mode  = mode;
        cur_ar    = ar;
        cur_ac    = ac;
        cur_br    = br;
        cur_bc    = bc;
    endtask

    task automatic random_config();
        logic [1:0]  mode;
        logic [3:0]  ar;
        logic [3:0]  ac;
        logic [3:0]  br;
        logic [3:0]  bc;
        logic [15:0] scale;
        mode = 2'($urandom_range(3));
        ar   = pick_dim();
        ac   = pick_dim();
        br   = pick_dim();
        bc   = pick_dim();
        if ($urandom_range(99) < 80)
        begin
            if (mode == MODE_MUL)
                br = ac;
            else
            begin
                br = ar;
                bc = ac;
            end
        end
        case ($urandom_range(7))
            0:       scale = 16'h8000;
            1:       scale = 16'h7FFF;
            2:       scale = 16'h0000;
            default: scale = 16'($urandom);
        endcase
        set_config(mode, ar, ac, br, bc, scale);
    endtask

    task automatic fill_region(logic [1:0] kind, int nr, int nc);
        int r;
        int c;
        bit done;
        for (r = 0; r < nr; r++)
        begin
            for (c = 0; c < nc; c++)
            begin
                done = (kind == KIND_WR_A) ? written_a[r*STORE_DIM+c] : written_b[r*STORE_DIM+c];
                if (!done)
                    send_beat(kind, r[2:0], c[2:0], rand_elem());
            end
        end
    endtask

    // entries that a run will read must have been written
    task automatic load_missing();
        int ar;
        int ac;
        int br;
        int bc;
        ar = dim_of(cur_ar);
        ac = dim_of(cur_ac);
        br = dim_of(cur_br);
        bc = dim_of(cur_bc);
        case (cur_mode)
            MODE_MUL:
                if (ac == br)
                begin
                    fill_region(KIND_WR_A, ar, ac);
                    fill_region(KIND_WR_B, br, bc);
                end
            MODE_SCALE:
                fill_region(KIND_WR_A, ar, ac);
            default:
                if (ar == br && ac == bc)
                begin
                    fill_region(KIND_WR_A, ar, ac);
                    fill_region(KIND_WR_B, ar, ac);
                end
        endcase
    endtask

    task automatic do_run();
        load_missing();
        send_beat(KIND_RUN, 3'($urandom_range(7)), 3'($urandom_range(7)), 16'($urandom));
    endtask

    task automatic random_write();
        logic [1:0] kind;
        logic [2:0] row;
        logic [2:0] col;
        int nr;
        int nc;
        kind = $urandom_range(1) ? KIND_WR_B : KIND_WR_A;
        nr   = dim_of(kind == KIND_WR_A ? cur_ar : cur_br);
        nc   = dim_of(kind == KIND_WR_A ? cur_ac : cur_bc);
        row  = ($urandom_range(99) < 30) ? 3'($urandom_range(7)) : 3'($urandom_range(nr - 1));
        col  = ($urandom_range(99) < 30) ? 3'($urandom_range(7)) : 3'($urandom_range(nc - 1));
        send_beat(kind, row, col, rand_elem());
    endtask

    initial
    begin
        set_pace();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, every mode, mismatches, degenerate sizes
        set_config(MODE_ADD, 4'd2, 4'd2, 4'd2, 4'd2, 16'h8000);
        send_beat(KIND_WR_A, 3'd0, 3'd0, 16'h7FFF);
        send_beat(KIND_WR_A, 3'd0, 3'd1, 16'h8000);
        send_beat(KIND_WR_A, 3'd1, 3'd0, 16'h0000);
        send_beat(KIND_WR_A, 3'd1, 3'd1, 16'hFFFF);
        send_beat(KIND_WR_B, 3'd0, 3'd0, 16'h7FFF);
        send_beat(KIND_WR_B, 3'd0, 3'd1, 16'h8000);
        send_beat(KIND_WR_B, 3'd1, 3'd0, 16'h8000);
        send_beat(KIND_WR_B, 3'd1, 3'd1, 16'h0001);
        send_beat(KIND_WR_A, 3'd7, 3'd7, 16'h5555);
        send_beat(KIND_WR_B, 3'd7, 3'd7, 16'hAAAA);
        send_beat(KIND_NONE, 3'd3, 3'd4, 16'h1234);
        do_run();
        set_config(MODE_SUB, 4'd2, 4'd2, 4'd2, 4'd2, 16'h8000);
        do_run();
        set_config(MODE_MUL, 4'd2, 4'd2, 4'd2, 4'd2, 16'h8000);
        do_run();
        set_config(MODE_SCALE, 4'd2, 4'd2, 4'd0, 4'd0, 16'h8000);
        do_run();
        set_config(MODE_SCALE, 4'd0, 4'd0, 4'd2, 4'd2, 16'h7FFF);
        do_run();
        set_config(MODE_MUL, 4'd2, 4'd3, 4'd2, 4'd2, 16'h0001);
        do_run();
        set_config(MODE_ADD, 4'd2, 4'd2, 4'd2, 4'd1, 16'h0001);
        do_run();
        set_config(MODE_MUL, 4'd1, 4'd2, 4'd2, 4'd1, 16'h0001);
        do_run();

        while (items_sent < ITEM_TARGET)
        begin
            set_pace();
            if ($urandom_range(99) < 35)
                random_config();
            repeat ($urandom_range(6)) random_write();
            if ($urandom_range(99) < 6)
                send_beat(KIND_NONE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                          16'($urandom));
            if ($urandom_range(99) < 4)
                wait_drained();
            do_run();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("[matrix_arithmetic_engine_top] OK");
        else
            $display("[matrix_arithmetic_engine_top] ERROR");
        $finish;
    end

endmodule
